// ----- hw/rtl/fats_pkg.sv -----
// ----------------------------------------------------------------------------
// fats_pkg
// Shared types for the FIFO-replacement fully associative tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fats_pkg;

  localparam int unsigned CfgBits   = 6;
  localparam int unsigned InBits    = 16;
  localparam int unsigned EvictBits = 16;
  localparam int unsigned MissBits  = 32;
  localparam int unsigned OutBits   = EvictBits + MissBits;
  localparam int unsigned UserBits  = 2;
  localparam logic [CfgBits-1:0] CapReset = 6'd32;

  typedef struct packed {
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

// ----- hw/rtl/fats_ctrl.sv -----
// ----------------------------------------------------------------------------
// fats_ctrl
// Sequencer: take one item, compare, then commit the replacement update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fats_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  fats_pkg::dp_status_t status_i,
  output fats_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_COMMIT = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.lookup = 1'b1;
          state_d      = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!status_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/fats_dp.sv -----
// ----------------------------------------------------------------------------
// fats_dp
// Tag array, valid bits, ring pointers, miss counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fats_dp #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fats_pkg::CfgBits-1:0]      cfg_wdata_i,
  input  logic [fats_pkg::InBits-1:0]       in_id_i,
  input  fats_pkg::ctrl_cmd_t               cmd_i,
  output fats_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fats_pkg::OutBits-1:0]      out_data_o,
  output logic [fats_pkg::UserBits-1:0]     out_user_o
);

  localparam int unsigned PW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CAPW = (CW > fats_pkg::CfgBits) ? CW : fats_pkg::CfgBits;
  localparam int unsigned EB   = fats_pkg::EvictBits;
  localparam int unsigned MB   = fats_pkg::MissBits;

  logic [ID_BITS-1:0]             tags_q [ENTRIES];
  logic [ENTRIES-1:0]             valid_q, valid_d;
  logic [ENTRIES-1:0]             match_q, match_d;
  logic [ID_BITS-1:0]             id_q, id_in;
  logic [PW-1:0]                  oldest_q, oldest_d;
  logic [CW-1:0]                  fill_q, fill_d;
  logic [MB-1:0]                  miss_q, miss_d;
  logic [fats_pkg::CfgBits-1:0]   cap_q;
  logic [CAPW-1:0]                cap_eff;
  logic [SW-1:0]                  slot_sum;
  logic [PW-1:0]                  slot;
  logic [ID_BITS+EB-1:0]          in_wide;
  logic [ID_BITS+EB-1:0]          old_wide;
  logic [EB-1:0]                  evict_id;
  logic                           hit, evict, out_valid_q;
  logic [fats_pkg::OutBits-1:0]   out_data_q;
  logic [fats_pkg::UserBits-1:0]  out_user_q;

  assign in_wide = {{ID_BITS{1'b0}}, in_id_i};
  assign id_in   = in_wide[ID_BITS-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = valid_q[i] && (tags_q[i] == id_in);
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAPW'(1);
    end else if (CAPW'(cap_q) > CAPW'(ENTRIES)) begin
      cap_eff = CAPW'(ENTRIES);
    end else begin
      cap_eff = CAPW'(cap_q);
    end
  end

  assign hit   = |match_q;
  assign evict = !hit && (CAPW'(fill_q) >= cap_eff);

  always_comb begin
    slot_sum = SW'(oldest_q) + SW'(fill_q);
    if (slot_sum >= SW'(ENTRIES)) begin
      slot_sum = slot_sum - SW'(ENTRIES);
    end
    slot = slot_sum[PW-1:0];
  end

  assign old_wide = {{EB{1'b0}}, tags_q[oldest_q]};
  assign evict_id = evict ? old_wide[EB-1:0] : '0;

  always_comb begin
    valid_d  = valid_q;
    oldest_d = oldest_q;
    fill_d   = fill_q;
    miss_d   = miss_q;
    if (!hit) begin
      if (evict) begin
        valid_d[oldest_q] = 1'b0;
        oldest_d = (oldest_q == PW'(ENTRIES - 1)) ? '0 : oldest_q + 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
      valid_d[slot] = 1'b1;
      if (miss_q != '1) begin
        miss_d = miss_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      oldest_q <= '0;
      fill_q   <= '0;
      miss_q   <= '0;
      cap_q    <= fats_pkg::CapReset;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        valid_q  <= valid_d;
        oldest_q <= oldest_d;
        fill_q   <= fill_d;
        miss_q   <= miss_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      match_q <= match_d;
      id_q    <= id_in;
    end
    if (cmd_i.commit && !hit) begin
      tags_q[slot] <= id_q;
    end
    if (cmd_i.commit) begin
      out_data_q <= {miss_d, evict_id};
      out_user_q <= {evict, hit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;
  assign out_user_o         = out_user_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'($countones(valid_q)) == fill_q)
    else $error("valid bits disagree with fill count");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(match_q))
    else $error("tag present in more than one entry");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed item not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !status_o.out_stall)
    else $error("commit while output held");

endmodule

// ----- hw/rtl/fifo_fully_assoc_tag_store.sv -----
// ----------------------------------------------------------------------------
// fifo_fully_assoc_tag_store
// Fully associative tag store with FIFO replacement and a saturating miss
// count.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: block_id
//   m_axis    out  m_axis_tvalid / m_axis_tready  tuser: hit, evict_valid
//                                                 tdata: evicted_id, miss_total
//   cfg       in   cfg_we_i                       cfg_wdata_i: active_entries
//
// Each item gets a parallel compare against all tags, then the replacement
// update that loads the output register; the next block_id waits for it.
// The update cycle waits while the output register holds an untaken item.
// Reset leaves every entry invalid and capacity at 32; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_fully_assoc_tag_store #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fats_pkg::CfgBits-1:0]      cfg_wdata_i,   // active_entries
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fats_pkg::InBits-1:0]       s_axis_tdata,  // block_id
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fats_pkg::OutBits-1:0]      m_axis_tdata,  // evicted_id, miss_total
  output logic [fats_pkg::UserBits-1:0]     m_axis_tuser   // hit, evict_valid
);

  fats_pkg::ctrl_cmd_t  cmd;
  fats_pkg::dp_status_t status;

  fats_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  fats_dp #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_id_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ----- verif/fifo_fully_assoc_tag_store_tb.sv -----
// ----------------------------------------------------------------------------
// fifo_fully_assoc_tag_store_tb
// Self-checking bench for the FIFO-replacement tag store. A short table of
// lookups covers fresh entries, hits, forced evictions at capacity one, the
// zero and oversized capacity codes and a capacity cut below the fill. It is
// followed by random lookups drawn mostly from a small per-phase working set,
// so that hits and evictions both occur. A local tag ring predicts every
// result. Capacity changes only while the pipeline is drained. Sender gaps,
// receiver stalls and one long output hold-off vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_fully_assoc_tag_store_tb;

  localparam int unsigned ENTRIES    = 32;
  localparam int unsigned ID_W       = fats_pkg::InBits;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 180;
  localparam int unsigned POOL_SZ    = 40;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned STALL_MAX  = 4000;
  localparam int unsigned DIR_LEN    = 24;

  typedef struct packed {
    logic            hit;
    logic            evict_valid;
    logic [15:0]     evicted_id;
    logic [31:0]     miss_total;
  } lookup_res_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_LIT} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [15:0]     val;
    lookup_res_t     res;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [fats_pkg::CfgBits-1:0]  cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [fats_pkg::InBits-1:0]   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [fats_pkg::OutBits-1:0]  m_axis_tdata;
  logic [fats_pkg::UserBits-1:0] m_axis_tuser;

  fifo_fully_assoc_tag_store #(
    .ENTRIES(ENTRIES),
    .ID_BITS(ID_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // tag ring of the predictor
  logic [15:0]                   ring_tag [ENTRIES];
  logic                          ring_vld [ENTRIES];
  logic [4:0]                    ring_head;
  logic [5:0]                    ring_fill;
  logic [31:0]                   fetch_cnt;
  logic [fats_pkg::CfgBits-1:0]  cap_reg;

  lookup_res_t                   pending_res [$];
  int unsigned                   mismatches;
  int unsigned                   quiet_cycles;
  int unsigned                   send_idle_pct;
  int unsigned                   recv_stall_pct;
  bit                            hold_req;

  dir_row_t dir_tab [DIR_LEN] = '{
    '{ROW_LIT,  16'h0000, '{1'b0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_LIT,  16'hFFFF, '{1'b0, 1'b0, 16'h0000, 32'd2}},
    '{ROW_LIT,  16'h0000, '{1'b1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_LIT,  16'hFFFF, '{1'b1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_CFG,  16'd1,    '0},
    '{ROW_LIT,  16'h1234, '{1'b0, 1'b1, 16'h0000, 32'd3}},
    '{ROW_LIT,  16'hFFFF, '{1'b1, 1'b0, 16'h0000, 32'd3}},
    '{ROW_LIT,  16'h5555, '{1'b0, 1'b1, 16'hFFFF, 32'd4}},
    '{ROW_LIT,  16'hAAAA, '{1'b0, 1'b1, 16'h1234, 32'd5}},
    '{ROW_CFG,  16'd0,    '0},
    '{ROW_LIT,  16'hAAAA, '{1'b1, 1'b0, 16'h0000, 32'd5}},
    '{ROW_LIT,  16'h0001, '{1'b0, 1'b1, 16'h5555, 32'd6}},
    '{ROW_CFG,  16'd63,   '0},
    '{ROW_PRED, 16'h8000, '0},
    '{ROW_PRED, 16'h4000, '0},
    '{ROW_PRED, 16'h0100, '0},
    '{ROW_PRED, 16'h00FF, '0},
    '{ROW_CFG,  16'd2,    '0},
    '{ROW_PRED, 16'h7FFF, '0},
    '{ROW_PRED, 16'h0001, '0},
    '{ROW_PRED, 16'h00FF, '0},
    '{ROW_CFG,  16'd32,   '0},
    '{ROW_PRED, 16'h0002, '0},
    '{ROW_PRED, 16'hAAAA, '0}
  };

  function automatic lookup_res_t predict_lookup(input logic [15:0] id);
    lookup_res_t r;
    logic        found;
    int unsigned cap;
    logic [4:0]  slot;
    r     = '0;
    found = 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (ring_vld[k] && ring_tag[k] == id) found = 1'b1;
    end
    cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
    if (!found) begin
      if (ring_fill >= cap) begin
        r.evict_valid      = 1'b1;
        r.evicted_id       = ring_tag[ring_head];
        ring_vld[ring_head] = 1'b0;
        ring_head          = ring_head + 5'd1;
        ring_fill          = ring_fill - 6'd1;
      end
      slot           = ring_head + ring_fill[4:0];
      ring_tag[slot] = id;
      ring_vld[slot] = 1'b1;
      ring_fill      = ring_fill + 6'd1;
      if (fetch_cnt != 32'hFFFF_FFFF) fetch_cnt = fetch_cnt + 32'd1;
    end
    r.hit        = found;
    r.miss_total = fetch_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // drain, then write capacity
  task automatic set_capacity(input logic [fats_pkg::CfgBits-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg     = v;
  endtask

  task automatic send_item(input logic [15:0] id, input bit use_lit,
                           input lookup_res_t lit);
    lookup_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_lookup(id);
    pending_res.insert(pending_res.size(), use_lit ? lit : r);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
  end
  always #10 clk_i = ~clk_i;

  // receiver
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    lookup_res_t got;
    lookup_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit         = m_axis_tuser[0];
      got.evict_valid = m_axis_tuser[1];
      got.evicted_id  = m_axis_tdata[15:0];
      got.miss_total  = m_axis_tdata[47:16];
      if (pending_res.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(got.evicted_id), 32'd0);
      end else begin
        want = pending_res[0];
        pending_res.delete(0);
        if (got.hit != want.hit)
          report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.evict_valid != want.evict_valid)
          report_mismatch("evict_valid", 32'(got.evict_valid), 32'(want.evict_valid));
        if (got.evicted_id != want.evicted_id)
          report_mismatch("evicted_id", 32'(got.evicted_id), 32'(want.evicted_id));
        if (got.miss_total != want.miss_total)
          report_mismatch("miss_total", got.miss_total, want.miss_total);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] pool [POOL_SZ];
    logic [15:0] id;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      ring_tag[k] = '0;
      ring_vld[k] = 1'b0;
    end
    ring_head = '0;
    ring_fill = '0;
    fetch_cnt = '0;
    cap_reg   = fats_pkg::CapReset;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_LEN; i++) begin
      case (dir_tab[i].kind)
        ROW_CFG:  set_capacity(dir_tab[i].val[fats_pkg::CfgBits-1:0]);
        ROW_PRED: send_item(dir_tab[i].val, 1'b0, '0);
        default:  send_item(dir_tab[i].val, 1'b1, dir_tab[i].res);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_capacity(6'd32);
        1:       set_capacity(6'd1);
        2:       set_capacity(6'd0);
        3:       set_capacity(6'd63);
        6:       set_capacity(6'd4);
        7:       set_capacity(6'd16);
        default: set_capacity(6'($urandom_range(63)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int k = 0; k < POOL_SZ; k++) pool[k] = 16'($urandom);
      if (p == 4) begin
        // fill the pipe against a held output
        @(posedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(99) < 70) id = pool[$urandom_range(POOL_SZ - 1)];
        else id = 16'($urandom);
        send_item(id, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/fats_pkg.sv
hw/rtl/fats_ctrl.sv
hw/rtl/fats_dp.sv
hw/rtl/fifo_fully_assoc_tag_store.sv
verif/fifo_fully_assoc_tag_store_tb.sv
